@@ design/table_keyed_string_hash_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the table-keyed string hash unit
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_KEYED_STRING_HASH_UNIT_ASSERT_SVH
`define TABLE_KEYED_STRING_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// implication check: antecedent and consequent written as a property
`define TKSH_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tksh assertion failed");
// condition that must never hold
`define TKSH_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tksh forbidden condition seen");
`else
`define TKSH_ASSERT(label, prop)
`define TKSH_NEVER(label, cond)
`endif

`endif

@@ design/tksh_pkg.sv @@
// ----------------------------------------------------------------------------
// Table-keyed string hash package
// Field widths, register indexes, seed resets and the fixed key table.
// ----------------------------------------------------------------------------
`default_nettype none

package tksh_pkg;

	localparam int ByteWidth  = 8;
	localparam int WordWidth  = 32;
	localparam int KeyWords   = 256;
	localparam int IndexWidth = 1;

	typedef enum logic [IndexWidth-1:0] {
		REG_INITIAL_SEED_ONE = 1'b0,
		REG_INITIAL_SEED_TWO = 1'b1
	} reg_index_t;

	localparam logic [WordWidth-1:0] SeedOneReset = 32'h7FED_7FED;
	localparam logic [WordWidth-1:0] SeedTwoReset = 32'hEEEE_EEEE;

	localparam logic [WordWidth-1:0] GenStart   = 32'h0010_0001;
	localparam logic [WordWidth-1:0] GenMult    = 32'd125;
	localparam logic [WordWidth-1:0] GenAdd     = 32'd3;
	localparam logic [WordWidth-1:0] GenModulus = 32'h002A_AAAB;
	localparam logic [WordWidth-1:0] HalfMask   = 32'h0000_FFFF;
	localparam int                   GenWords   = 5;
	localparam int                   KeptWord   = 1;

	localparam logic [WordWidth-1:0] SeedTwoAdd = 32'd3;

	typedef logic [WordWidth-1:0] key_table_t [KeyWords];

	// elaboration-time build of the key table slice
	function automatic key_table_t build_key_table();
		key_table_t             tbl;
		logic [WordWidth-1:0]   s;
		logic [WordWidth-1:0]   hi;
		logic [WordWidth-1:0]   lo;
		s = GenStart;
		for (int idx = 0; idx < KeyWords; idx++) begin
			for (int k = 0; k < GenWords; k++) begin
				s  = (s * GenMult + GenAdd) % GenModulus;
				hi = (s & HalfMask) << 16;
				s  = (s * GenMult + GenAdd) % GenModulus;
				lo = s & HalfMask;
				if (k == KeptWord) begin
					tbl[idx] = hi | lo;
				end
			end
		end
		return tbl;
	endfunction

	localparam key_table_t KeyTable = build_key_table();

endpackage

`default_nettype wire

@@ design/tksh_in_if.sv @@
// ----------------------------------------------------------------------------
// Table-keyed string hash input channel
// Valid/ready channel carrying one message byte item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksh_in_if;
	logic                            valid;
	logic                            ready;
	logic [tksh_pkg::ByteWidth-1:0]  byte_value;
	logic                            has_byte;
	logic                            last_item;

	modport source (output valid, output byte_value, output has_byte,
		output last_item, input ready);
	modport sink (input valid, input byte_value, input has_byte,
		input last_item, output ready);
endinterface

`default_nettype wire

@@ design/tksh_out_if.sv @@
// ----------------------------------------------------------------------------
// Table-keyed string hash result channel
// Valid/ready channel carrying one hash result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksh_out_if;
	logic                            valid;
	logic                            ready;
	logic [tksh_pkg::WordWidth-1:0]  hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

@@ design/table_keyed_string_hash_unit.sv @@
// ----------------------------------------------------------------------------
// Table-keyed string hash unit
// One-way string hash over a byte stream using a fixed 256-word key table.
// ----------------------------------------------------------------------------
// Each accepted item is held in the input register, where the key table
// lookup and the seed update run; unless a stall holds the unit, the next
// item may be accepted in every cycle, so the unit sustains one byte per
// clock. A hash is loaded into the result register at the clock edge where
// the last item of a message leaves the input register.
// The seeds are loaded from the initial seed registers at the first item of
// each message, so a register write applies from the next message on. The
// unit stalls only while a finished hash waits and another last item is
// pending.
`default_nettype none

`include "table_keyed_string_hash_unit_assert.svh"

module table_keyed_string_hash_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	tksh_in_if.sink                                 items,
	tksh_out_if.source                              results,
	input  wire logic                               wr_en,
	input  wire logic [tksh_pkg::IndexWidth-1:0]    wr_index,
	input  wire logic [tksh_pkg::WordWidth-1:0]     wr_data
);

	logic [tksh_pkg::WordWidth-1:0] init_one_q;
	logic [tksh_pkg::WordWidth-1:0] init_two_q;

	logic                           valid_s1;
	logic [tksh_pkg::ByteWidth-1:0] byte_s1;
	logic                           has_s1;
	logic                           last_s1;

	logic [tksh_pkg::WordWidth-1:0] seed_one_q;
	logic [tksh_pkg::WordWidth-1:0] seed_two_q;
	logic                           mid_q;

	logic                           out_valid_q;
	logic [tksh_pkg::WordWidth-1:0] hash_q;

	logic                           advance;
	logic [tksh_pkg::WordWidth-1:0] cur_one;
	logic [tksh_pkg::WordWidth-1:0] cur_two;
	logic [tksh_pkg::WordWidth-1:0] key_word;
	logic [tksh_pkg::WordWidth-1:0] next_one;
	logic [tksh_pkg::WordWidth-1:0] next_two;

	// hold a last item while the previous hash is still waiting
	assign advance     = valid_s1 && !(last_s1 && out_valid_q && !results.ready);
	assign items.ready = !valid_s1 || advance;

	assign cur_one  = mid_q ? seed_one_q : init_one_q;
	assign cur_two  = mid_q ? seed_two_q : init_two_q;
	assign key_word = tksh_pkg::KeyTable[byte_s1];

	always_comb begin
		next_one = cur_one;
		next_two = cur_two;
		if (has_s1) begin
			next_one = key_word ^ (cur_one + cur_two);
			next_two = {{(tksh_pkg::WordWidth-tksh_pkg::ByteWidth){1'b0}}, byte_s1}
				+ next_one + cur_two + (cur_two << 5) + tksh_pkg::SeedTwoAdd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_one_q <= tksh_pkg::SeedOneReset;
			init_two_q <= tksh_pkg::SeedTwoReset;
		end else if (wr_en) begin
			unique case (tksh_pkg::reg_index_t'(wr_index))
				tksh_pkg::REG_INITIAL_SEED_ONE: init_one_q <= wr_data;
				tksh_pkg::REG_INITIAL_SEED_TWO: init_two_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				mid_q <= !last_s1;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			byte_s1 <= items.byte_value;
			has_s1  <= items.has_byte;
			last_s1 <= items.last_item;
		end
		if (advance) begin
			seed_one_q <= next_one;
			seed_two_q <= next_two;
		end
		if (advance && last_s1) begin
			hash_q <= next_one;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.hash_value = hash_q;

	`TKSH_ASSERT(a_stall_cause, !items.ready |-> (valid_s1 && last_s1 && out_valid_q))
	`TKSH_ASSERT(a_last_loads_result, (advance && last_s1) |=> out_valid_q)
	`TKSH_ASSERT(a_last_ends_message, (advance && last_s1) |=> !mid_q)
	`TKSH_ASSERT(a_body_keeps_message, (advance && !last_s1) |=> mid_q)

endmodule

`default_nettype wire
